// File: design/mtpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtpa_pkg
// Shared types and constants of the p-value adjustment block.
// ----------------------------------------------------------------------------
package mtpa_pkg;

  localparam int PW           = 17;
  localparam int ONE_Q16      = 65536;
  localparam int MAX_ITEMS_DEF = 64;
  localparam int HW           = 24;

  typedef enum logic [1:0] {
    M_BONF = 2'd0,
    M_HOCH = 2'd1,
    M_BH   = 2'd2,
    M_BY   = 2'd3
  } method_t;

  localparam logic [1:0] METHOD_RST = 2'd2;
  localparam logic [16:0] ALPHA_RST = 17'd3277;

  // register addresses, word index
  localparam logic ADDR_METHOD = 1'b0;
  localparam logic ADDR_ALPHA  = 1'b1;

  // queued entry between loader and adjust engine
  typedef struct packed {
    logic [PW-1:0] p;
    logic          last;
  } qent_t;

endpackage

// File: design/mtpa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtpa_front
// Input skid queue: accepts p-values and holds them until the engine takes them.
// ----------------------------------------------------------------------------
module mtpa_front #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mtpa_pkg::qent_t    in_ent,
  output logic               q_valid,
  input  logic               q_ready,
  output mtpa_pkg::qent_t    q_ent
);

  localparam int AW = $clog2(DEPTH);

  mtpa_pkg::qent_t     mem_r [DEPTH];
  logic [AW-1:0]       wp_r, rp_r;
  logic [AW:0]         cnt_r;
  logic                push, pop;

  assign in_ready = (cnt_r != (AW+1)'(DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_ent    = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_ent;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  property p_no_overflow;
    @(posedge clk) disable iff (!rst_n) cnt_r <= (AW+1)'(DEPTH);
  endproperty
  a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

  property p_pop_nonempty;
    @(posedge clk) disable iff (!rst_n) pop |-> cnt_r != '0;
  endproperty
  a_pop_nonempty: assert property (p_pop_nonempty) else $error("pop from empty");

  property p_cnt_step;
    @(posedge clk) disable iff (!rst_n) (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1;
  endproperty
  a_cnt_step: assert property (p_cnt_step) else $error("count mismatch");

endmodule

// File: design/mtpa_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtpa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mtpa_div #(
  parameter int NW = 48,
  parameter int DW = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW+1);

  logic [NW-1:0] q_r;
  logic [DW:0]   rem_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [DW+1:0] trial;
  logic [DW:0]   shifted;

  assign shifted = {rem_r[DW-1:0], q_r[NW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den};
  assign done    = done_r;
  assign quo     = q_r;

  // shift-subtract iteration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
        q_r    <= num;
        rem_r  <= '0;
      end else if (busy_r) begin
        if (!trial[DW+1]) begin
          rem_r <= trial[DW:0];
          q_r   <= {q_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= shifted;
          q_r   <= {q_r[NW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// File: design/mtpa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtpa_back
// Adjust engine: stores a set, ranks it, scales it (with a running minimum
// except under Bonferroni) and emits results in input order.
// ----------------------------------------------------------------------------
module mtpa_back #(
  parameter int MAX_ITEMS = mtpa_pkg::MAX_ITEMS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  output logic                     q_ready,
  input  mtpa_pkg::qent_t          q_ent,
  input  logic [1:0]               method,
  input  logic [mtpa_pkg::PW-1:0]  alpha,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [mtpa_pkg::PW-1:0]  out_adjusted_p,
  output logic                     out_reject,
  output logic                     out_last_out
);

  localparam int PW = mtpa_pkg::PW;
  localparam int HW = mtpa_pkg::HW;
  localparam int AW = $clog2(MAX_ITEMS);
  localparam int NW = AW + 1;
  localparam int SW = PW + NW;            // n*p
  localparam int BW = SW + HW;            // Hn*n*p
  localparam int DNW = NW + 16;           // k<<16

  typedef enum logic [3:0] {
    S_LOAD, S_RK_RD, S_RK_CMP, S_RK_WR, S_HS_GO, S_HS_DIV, S_AD_RD, S_AD_MUL,
    S_AD_MUL2, S_AD_HMUL, S_AD_DIV, S_AD_WR, S_EM_RD, S_EM_OUT
  } state_t;

  state_t         state_r;
  logic [PW-1:0]  val_mem [MAX_ITEMS];
  logic [AW-1:0]  idx_mem [MAX_ITEMS];
  logic [PW-1:0]  adj_mem [MAX_ITEMS];

  logic [NW-1:0]  n_r;
  logic [HW-1:0]  h_r;
  logic [AW-1:0]  i_r, j_r;
  logic [PW-1:0]  vi_r, vj_r;
  logic [AW-1:0]  cnt_r;
  logic [AW:0]    r_r;
  logic [AW-1:0]  idx_r;
  logic [BW-1:0]  prod_r;
  logic [BW-1:0]  run_r;
  logic           run_ok_r;
  logic [PW-1:0]  adj_rd_r;
  logic [NW-1:0]  k_w;
  logic [NW-1:0]  n_inc;
  logic [NW-1:0]  j_inc;
  logic [AW-1:0]  rd_a;
  logic           hs_phase;
  logic           div_start_r;
  logic [BW-1:0]  div_num;
  logic [DNW-1:0] div_den;
  logic           div_done;
  logic [BW-1:0]  div_quo;
  logic [BW-1:0]  scaled;
  logic [BW-1:0]  mn;
  logic [PW-1:0]  clip;

  assign q_ready  = (state_r == S_LOAD);
  assign k_w      = r_r[NW-1:0] + 1'b1;
  assign n_inc    = n_r + 1'b1;
  assign j_inc    = NW'(j_r) + 1'b1;
  // value store read port shared by ranking and scaling
  assign rd_a     = (state_r == S_AD_MUL) ? idx_r : i_r;
  assign hs_phase = (state_r == S_HS_GO) || (state_r == S_HS_DIV);

  mtpa_div #(.NW(BW), .DW(DNW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start_r),
    .num(div_num), .den(div_den), .done(div_done), .quo(div_quo));

  // divider feeds 65536/j for the harmonic sum, else the scaled product
  assign div_den = hs_phase ? DNW'(j_inc) :
                   (method == mtpa_pkg::M_BY) ? {k_w, 16'd0} : DNW'(k_w);
  assign div_num = hs_phase ? BW'(mtpa_pkg::ONE_Q16) : prod_r;

  // running minimum and clip
  always_comb begin
    scaled = (method == mtpa_pkg::M_BH || method == mtpa_pkg::M_BY) ? div_quo : prod_r;
    mn = scaled;
    if (method != mtpa_pkg::M_BONF && run_ok_r && run_r < scaled) mn = run_r;
    clip = (mn > BW'(mtpa_pkg::ONE_Q16)) ? PW'(mtpa_pkg::ONE_Q16) : mn[PW-1:0];
  end

  // stores
  always_ff @(posedge clk) begin
    if (state_r == S_LOAD && q_valid) val_mem[n_r[AW-1:0]] <= q_ent.p;
    if (state_r == S_RK_WR) idx_mem[cnt_r] <= i_r;
    if (state_r == S_AD_WR) adj_mem[idx_r] <= clip;
    vi_r     <= val_mem[rd_a];
    vj_r     <= val_mem[j_r];
    idx_r    <= idx_mem[r_r[AW-1:0]];
    adj_rd_r <= adj_mem[i_r];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      n_r         <= '0;
      h_r         <= '0;
      out_valid   <= 1'b0;
      div_start_r <= 1'b0;
      run_ok_r    <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      unique case (state_r)
        S_LOAD: begin
          if (q_valid) begin
            n_r <= n_inc;
            if (q_ent.last || n_inc == NW'(MAX_ITEMS)) begin
              state_r <= S_RK_RD;
              i_r <= '0;
              j_r <= '0;
              cnt_r <= '0;
            end
          end
        end
        S_RK_RD: state_r <= S_RK_CMP;
        S_RK_CMP: begin
          if (vj_r < vi_r || (vj_r == vi_r && j_r < i_r)) cnt_r <= cnt_r + 1'b1;
          if (NW'(j_r) == n_r - 1'b1) state_r <= S_RK_WR;
          else begin
            j_r <= j_r + 1'b1;
            state_r <= S_RK_RD;
          end
        end
        S_RK_WR: begin
          cnt_r <= '0;
          j_r <= '0;
          if (NW'(i_r) == n_r - 1'b1) begin
            r_r <= (AW+1)'(n_r - 1'b1);
            run_ok_r <= 1'b0;
            if (method == mtpa_pkg::M_BY) state_r <= S_HS_GO;
            else state_r <= S_AD_RD;
          end else begin
            i_r <= i_r + 1'b1;
            state_r <= S_RK_RD;
          end
        end
        // harmonic sum, one division 65536/j per stored value
        S_HS_GO: begin
          div_start_r <= 1'b1;
          state_r <= S_HS_DIV;
        end
        S_HS_DIV: begin
          if (div_done) begin
            h_r <= h_r + HW'(div_quo[PW:0]);
            if (j_inc == n_r) state_r <= S_AD_RD;
            else begin
              j_r <= j_r + 1'b1;
              state_r <= S_HS_GO;
            end
          end
        end
        S_AD_RD: state_r <= S_AD_MUL;      // idx_r loading
        S_AD_MUL: begin
          // vi_r holds the value at idx_r next cycle
          state_r <= S_AD_MUL2;
        end
        S_AD_MUL2: begin
          unique case (method)
            mtpa_pkg::M_BONF, mtpa_pkg::M_BH, mtpa_pkg::M_BY:
              prod_r <= BW'(n_r) * BW'(vi_r);
            default: prod_r <= BW'(n_r - r_r[NW-1:0]) * BW'(vi_r);
          endcase
          if (method == mtpa_pkg::M_BY) state_r <= S_AD_HMUL;
          else if (method == mtpa_pkg::M_BH) begin
            div_start_r <= 1'b1;
            state_r <= S_AD_DIV;
          end else state_r <= S_AD_WR;
        end
        // second product stage, Hn times n*p
        S_AD_HMUL: begin
          prod_r <= BW'(h_r) * BW'(prod_r[SW-1:0]);
          div_start_r <= 1'b1;
          state_r <= S_AD_DIV;
        end
        S_AD_DIV: if (div_done) state_r <= S_AD_WR;
        S_AD_WR: begin
          run_r <= mn;
          run_ok_r <= 1'b1;
          if (r_r == '0) begin
            state_r <= S_EM_RD;
            i_r <= '0;
          end else begin
            r_r <= r_r - 1'b1;
            state_r <= S_AD_RD;
          end
        end
        S_EM_RD: state_r <= S_EM_OUT;
        S_EM_OUT: begin
          if (!out_valid) begin
            out_valid      <= 1'b1;
            out_adjusted_p <= adj_rd_r;
            out_reject     <= adj_rd_r <= alpha;
            out_last_out   <= (NW'(i_r) == n_r - 1'b1);
          end else if (out_ready) begin
            out_valid <= 1'b0;
            if (out_last_out) begin
              state_r <= S_LOAD;
              n_r <= '0;
              h_r <= '0;
            end else begin
              i_r <= i_r + 1'b1;
              state_r <= S_EM_RD;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  property p_out_only_emit;
    @(posedge clk) disable iff (!rst_n) out_valid |-> state_r == S_EM_OUT;
  endproperty
  a_out_only_emit: assert property (p_out_only_emit) else $error("output outside emit");

  property p_load_ready;
    @(posedge clk) disable iff (!rst_n) q_ready |-> n_r < NW'(MAX_ITEMS);
  endproperty
  a_load_ready: assert property (p_load_ready) else $error("store overrun");

  property p_clip;
    @(posedge clk) disable iff (!rst_n) out_valid |-> out_adjusted_p <= PW'(mtpa_pkg::ONE_Q16);
  endproperty
  a_clip: assert property (p_clip) else $error("result not clipped");

endmodule

// File: design/multiple_test_pvalue_adjust.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiple_test_pvalue_adjust
// Multiple-test p-value adjustment, four methods, Q1.16 values.
// ----------------------------------------------------------------------------
// Usage: p-values enter on in_valid/in_ready, one transfer per cycle while
// in_ready is high, into a four-entry queue, until a transfer with
// in_last_in high (or the store fills). The engine then ranks the set, one
// compare at a time on the value store ports. Under BY it next builds the
// harmonic sum, one serial division per stored value. It then scales each
// value from the largest rank down, using the serial divider under BH and
// BY, and emits n results in input order on out_valid/out_ready, one at a
// time. While the engine works the queue absorbs up to four new p-values,
// then in_ready drops. A stalled receiver simply holds the result register.
// Reset clears the set count and loads method 2 and significance 3277. The
// user must write the APB-style cfg port only while idle; the block itself
// does not enforce it. prdata returns registers.
// ----------------------------------------------------------------------------
module multiple_test_pvalue_adjust #(
  parameter int MAX_ITEMS = mtpa_pkg::MAX_ITEMS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [mtpa_pkg::PW-1:0] in_p_value,
  input  logic                    in_last_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [mtpa_pkg::PW-1:0] out_adjusted_p,
  output logic                    out_reject,
  output logic                    out_last_out,
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [2:0]              cfg_paddr,
  input  logic [31:0]             cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);

  logic [1:0]              method_r;
  logic [mtpa_pkg::PW-1:0] alpha_r;
  mtpa_pkg::qent_t         in_ent, q_ent;
  logic                    q_valid, q_ready;

  assign cfg_pready = 1'b1;
  assign in_ent.p    = in_p_value;
  assign in_ent.last = in_last_in;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_r <= mtpa_pkg::METHOD_RST;
      alpha_r  <= mtpa_pkg::ALPHA_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
      if (cfg_paddr[2] == mtpa_pkg::ADDR_METHOD) method_r <= cfg_pwdata[1:0];
      else alpha_r <= cfg_pwdata[16:0];
    end
  end

  // register reads
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == mtpa_pkg::ADDR_ALPHA) cfg_prdata = 32'(alpha_r);
    else cfg_prdata = 32'(method_r);
  end

  mtpa_front #(.DEPTH(4)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_ent(in_ent), .q_valid(q_valid), .q_ready(q_ready), .q_ent(q_ent));

  mtpa_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
    .q_ent(q_ent), .method(method_r), .alpha(alpha_r),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_adjusted_p(out_adjusted_p), .out_reject(out_reject),
    .out_last_out(out_last_out));

endmodule

// File: tb/tb_multiple_test_pvalue_adjust.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multiple_test_pvalue_adjust
// Self-checking bench for the p-value adjustment block. Sets of p-values are
// streamed in with random gaps and a back-pressured result port. A built-in
// predictor ranks each closed set and computes the adjusted values, reject
// flags and set markers, which are checked in order against every result
// transfer. All four methods and the edge significance levels are covered.
// ----------------------------------------------------------------------------
module tb_multiple_test_pvalue_adjust;

  localparam int PW = mtpa_pkg::PW;
  localparam int HW = mtpa_pkg::HW;
  localparam int SET_CAP = 64;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [2:0] METHOD_ADDR = {2'b00, mtpa_pkg::ADDR_METHOD} << 2;
  localparam logic [2:0] ALPHA_ADDR  = {2'b00, mtpa_pkg::ADDR_ALPHA} << 2;

  typedef struct packed {
    logic [PW-1:0] adj;
    logic          rej;
    logic          last;
  } adj_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [PW-1:0] in_p_value = '0;
  logic in_last_in = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PW-1:0] out_adjusted_p;
  logic out_reject;
  logic out_last_out;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  // predictor state
  mtpa_pkg::method_t cur_method = mtpa_pkg::M_BH;
  logic [PW-1:0] cur_alpha = mtpa_pkg::ALPHA_RST;
  logic [PW-1:0] set_vals[SET_CAP];
  int            set_cnt = 0;
  logic [HW-1:0] harm_sum = '0;

  mtpa_pkg::qent_t pend_q[$];
  adj_res_t        adj_q[$];

  int  err_cnt = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  sets_closed = 0;
  int  cycle_cnt = 0;
  bit  in_fired = 1'b0;
  int  in_gap = 0;
  int  out_gap = 0;
  int  hold_left = 0;
  bit  held_once = 1'b0;

  multiple_test_pvalue_adjust dut (.*);

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // rank the closed set and queue the adjusted results in input order
  function automatic void adjust_closed_set();
    int n;
    int by_rank[SET_CAP];
    logic [63:0] adj_val[SET_CAP];
    logic [63:0] running;
    logic [63:0] v;
    logic [63:0] pv;
    int r;
    int idx;
    adj_res_t res;
    n = set_cnt;
    for (int i = 0; i < n; i++) begin
      r = 0;
      for (int j = 0; j < n; j++)
        if (set_vals[j] < set_vals[i] || (set_vals[j] == set_vals[i] && j < i)) r++;
      by_rank[r] = i;
    end
    running = '1;
    for (int rk = n - 1; rk >= 0; rk--) begin
      idx = by_rank[rk];
      pv = 64'(set_vals[idx]);
      case (cur_method)
        mtpa_pkg::M_BONF: v = 64'(n) * pv;
        mtpa_pkg::M_HOCH: v = 64'(n - rk) * pv;
        mtpa_pkg::M_BH:   v = (64'(n) * pv) / 64'(rk + 1);
        default: v = (64'(harm_sum) * 64'(n) * pv) / (64'(rk + 1) << 16);
      endcase
      if (cur_method != mtpa_pkg::M_BONF) begin
        if (v < running) running = v;
        v = running;
      end
      if (v > mtpa_pkg::ONE_Q16) v = mtpa_pkg::ONE_Q16;
      adj_val[idx] = v;
    end
    for (int i = 0; i < n; i++) begin
      res.adj  = adj_val[i][PW-1:0];
      res.rej  = (adj_val[i][PW-1:0] <= cur_alpha);
      res.last = (i == n - 1);
      adj_q.push_back(res);
    end
    sets_closed++;
    set_cnt = 0;
    harm_sum = '0;
  endfunction

  // load one accepted p-value, close the set on last or full store
  function automatic void load_p_value(logic [PW-1:0] p, logic last);
    set_vals[set_cnt] = p;
    set_cnt++;
    harm_sum = harm_sum + HW'(mtpa_pkg::ONE_Q16 / set_cnt);
    if (last || set_cnt == SET_CAP) adjust_closed_set();
  endfunction

  // input monitor, result checker and cycle limit
  always @(posedge clk) begin
    adj_res_t exp_r;
    in_fired <= in_valid && in_ready;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
    if (rst_n && in_valid && in_ready) begin
      items_sent++;
      load_p_value(in_p_value, in_last_in);
    end
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (adj_q.size() == 0) begin
        $error("result transfer with nothing expected, adjusted_p %0d", out_adjusted_p);
        err_cnt++;
      end else begin
        exp_r = adj_q.pop_front();
        if (out_adjusted_p !== exp_r.adj) begin
          $error("adjusted_p expected %0d actual %0d", exp_r.adj, out_adjusted_p);
          err_cnt++;
        end
        if (out_reject !== exp_r.rej) begin
          $error("reject expected %0d actual %0d", exp_r.rej, out_reject);
          err_cnt++;
        end
        if (out_last_out !== exp_r.last) begin
          $error("last_out expected %0d actual %0d", exp_r.last, out_last_out);
          err_cnt++;
        end
      end
    end
  end

  function automatic int pick_gap();
    int d;
    d = $urandom_range(0, 19);
    if (d < 12) return 0;
    if (d < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // input driver
  always @(negedge clk) begin
    logic nv;
    mtpa_pkg::qent_t e;
    nv = in_valid;
    if (!rst_n) begin
      nv = 1'b0;
    end else if (!in_valid || in_fired) begin
      nv = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (pend_q.size() > 0) begin
        e = pend_q.pop_front();
        in_p_value <= e.p;
        in_last_in <= e.last;
        nv = 1'b1;
        in_gap = pick_gap();
      end
    end
    in_valid <= nv;
  end

  // result receiver, with one long hold-off while input keeps coming
  always @(negedge clk) begin
    logic nr;
    nr = 1'b1;
    if (hold_left > 0) begin
      hold_left--;
      nr = 1'b0;
    end else if (!held_once && results_seen >= 40) begin
      held_once = 1'b1;
      hold_left = 400;
      nr = 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      nr = 1'b0;
    end else begin
      out_gap = pick_gap();
    end
    out_ready <= nr;
  end

  function automatic logic [PW-1:0] pick_p();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return PW'(mtpa_pkg::ONE_Q16);
      2: return PW'($urandom_range(mtpa_pkg::ONE_Q16 + 1, 131071));
      3: return PW'($urandom);
      4, 5: return PW'($urandom_range(0, mtpa_pkg::ONE_Q16));
      default: return PW'($urandom_range(0, 4000));
    endcase
  endfunction

  // queue one set of n p-values, with ties mixed in; no last mark when full
  task automatic queue_set(int n);
    mtpa_pkg::qent_t e;
    logic [PW-1:0] prev;
    prev = pick_p();
    for (int i = 0; i < n; i++) begin
      e.p = ($urandom_range(0, 3) == 0) ? prev : pick_p();
      e.last = (i == n - 1) && (n < SET_CAP);
      prev = e.p;
      pend_q.push_back(e);
    end
  endtask

  task automatic queue_item(logic [PW-1:0] p, logic last);
    mtpa_pkg::qent_t e;
    e.p = p;
    e.last = last;
    pend_q.push_back(e);
  endtask

  // wait until every set is through and the engine has settled
  task automatic drain();
    while (!(pend_q.size() == 0 && !in_valid && adj_q.size() == 0)) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (addr == METHOD_ADDR) cur_method = mtpa_pkg::method_t'(data[1:0]);
    else cur_alpha = data[PW-1:0];
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic set_config(mtpa_pkg::method_t m, logic [PW-1:0] a);
    reg_write(METHOD_ADDR, 32'(m));
    reg_write(ALPHA_ADDR, 32'(a));
  endtask

  // stimulus
  initial begin
    mtpa_pkg::method_t phase_m[8];
    logic [PW-1:0] phase_a[8];
    int budget;
    int n;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed sets at reset settings: extremes, out-of-range, ties
    queue_item('0, 1'b1);
    queue_item(PW'(mtpa_pkg::ONE_Q16), 1'b1);
    queue_item(PW'(131071), 1'b1);
    queue_item(PW'(3277), 1'b0);
    queue_item(PW'(3277), 1'b0);
    queue_item(PW'(3277), 1'b1);
    queue_item(PW'(131071), 1'b0);
    queue_item('0, 1'b0);
    queue_item(PW'(65535), 1'b0);
    queue_item(PW'(1), 1'b0);
    queue_item(PW'(mtpa_pkg::ONE_Q16), 1'b1);
    queue_set(6);
    drain();

    phase_m = '{mtpa_pkg::M_BONF, mtpa_pkg::M_HOCH, mtpa_pkg::M_BY, mtpa_pkg::M_BH,
                mtpa_pkg::M_BONF, mtpa_pkg::M_BY, mtpa_pkg::M_HOCH, mtpa_pkg::M_BH};
    phase_a = '{PW'(0), PW'(mtpa_pkg::ONE_Q16), PW'(3277), PW'(0),
                PW'(mtpa_pkg::ONE_Q16), PW'(mtpa_pkg::ONE_Q16), PW'(0), PW'(0)};
    phase_a[2] = PW'($urandom_range(0, mtpa_pkg::ONE_Q16));
    phase_a[7] = PW'($urandom_range(0, mtpa_pkg::ONE_Q16));
    for (int ph = 0; ph < 8; ph++) begin
      set_config(phase_m[ph], phase_a[ph]);
      budget = 20;
      // a full store in phases 1 and 2 (M_HOCH and M_BY) exercises the implicit close
      if (ph == 1 || ph == 2) begin
        queue_set(SET_CAP);
        budget = 8;
      end
      while (budget > 0) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        if (n > budget) n = budget;
        queue_set(n);
        budget -= n;
      end
      drain();
    end

    $display("covered %0d p-values in %0d sets, %0d adjusted results checked",
             items_sent, sets_closed, results_seen);
    $display("all four methods, significance 0 and 1.0, ties, full store, long stall");
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
